/* design/pwm_generator_freq_duty_defines.svh */
// ----------------------------------------------------------------------------
// pwm generator assertion macros
// shared assertion helpers, clocked on aclk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef PWM_GENERATOR_FREQ_DUTY_DEFINES_SVH
`define PWM_GENERATOR_FREQ_DUTY_DEFINES_SVH

// same-cycle implication
`define PWMFD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PWMFD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/pwmfd_pkg.sv */
// ----------------------------------------------------------------------------
// pwmfd_pkg
// widths, register indexes, reset constants and shared types of the pwm block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pwmfd_pkg;

    // field and register widths
    localparam int FREQ_W     = 20;
    localparam int DUTY_W     = 8;
    localparam int DUTY_SAT_W = 7;
    localparam int CNT_W      = 16;
    localparam int CMP_W      = 17;
    localparam int PROD_W     = 24;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FREQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RUN  = 2'd2;

    // reset values and fixed constants
    localparam int unsigned RST_FREQ_HZ = 1000;
    localparam int unsigned RST_DUTY    = 50;
    localparam int unsigned DUTY_MAX    = 100;

    // pending reload/compare pair handed from the calculator to the counter
    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] reload;
        logic [CMP_W-1:0] compare;
    } pwmfd_pend_t;

endpackage

/* design/pwmfd_div.sv */
// ----------------------------------------------------------------------------
// pwmfd_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwmfd_div #(
    parameter int DW = 27,
    parameter int VW = 20
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quot_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;

    logic [VW:0]   shifted;
    logic [VW:0]   diff;
    logic          fits;

    // one trial subtraction per step
    assign shifted = {rem_reg, quot_reg[DW-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CW'(DW);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg  <= cnt_reg - CW'(1);
            done_reg <= (cnt_reg == CW'(1));
        end else begin
            done_reg <= 1'b0;
        end
    end

    // datapath, shifts dividend bits out and quotient bits in
    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end else if (cnt_reg != '0) begin
            quot_reg <= {quot_reg[DW-2:0], fits};
            rem_reg  <= fits ? diff[VW-1:0] : shifted[VW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

/* design/pwmfd_calc.sv */
// ----------------------------------------------------------------------------
// pwmfd_calc
// sequencer that derives the pending reload and compare pair on the divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwmfd_calc
    import pwmfd_pkg::*;
#(
    parameter int unsigned TICK_RATE_HZ = 1000000,
    parameter int unsigned RELOAD_MAX   = 65535,
    parameter int          DIV_W        = 27,
    parameter int unsigned RST_RELOAD   = 999,
    parameter int unsigned RST_COMPARE  = 500
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              restart,
    input  logic [FREQ_W-1:0] freq,
    input  logic [DUTY_W-1:0] duty,
    output pwmfd_pend_t       pend
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_F,
        S_FREQ,
        S_MUL,
        S_SCALE
    } state_t;

    localparam logic [DIV_W-1:0] TICKS_MAX = DIV_W'(RELOAD_MAX) + DIV_W'(1);

    // divide by 100 as multiply by reciprocal and shift, exact up to 65536*100
    localparam int                 RECIP_W    = 24;
    localparam int                 RECIP_SH   = 30;
    localparam logic [RECIP_W-1:0] DUTY_RECIP = 24'd10737419;
    localparam int                 SCALE_W    = PROD_W + RECIP_W;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    reload_reg, reload_next;
    logic [CMP_W-1:0]    compare_reg, compare_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    logic                div_start;
    logic [DIV_W-1:0]    div_dividend;
    logic [FREQ_W-1:0]   div_divisor;
    logic                div_done;
    logic [DIV_W-1:0]    div_quot;

    logic [FREQ_W-1:0]     freq_nz;
    logic [DUTY_SAT_W-1:0] duty_sat;
    logic [CMP_W-1:0]      reload_p1;
    logic [CNT_W-1:0]      reload_clamp;
    logic [SCALE_W-1:0]    scaled;

    // operand preparation
    assign freq_nz   = (freq == '0) ? FREQ_W'(1) : freq;
    assign duty_sat  = (duty > DUTY_W'(DUTY_MAX)) ? DUTY_SAT_W'(DUTY_MAX) : duty[DUTY_SAT_W-1:0];
    assign reload_p1 = CMP_W'(reload_reg) + CMP_W'(1);
    assign scaled    = SCALE_W'(prod_reg) * SCALE_W'(DUTY_RECIP);

    // period ticks clamped to 1..RELOAD_MAX+1, then minus one
    always_comb begin
        if (div_quot == '0) begin
            reload_clamp = '0;
        end else if (div_quot > TICKS_MAX) begin
            reload_clamp = CNT_W'(RELOAD_MAX);
        end else begin
            reload_clamp = CNT_W'(div_quot - DIV_W'(1));
        end
    end

    // divider request, tick rate over frequency
    assign div_start    = (state_reg == S_LOAD_F);
    assign div_dividend = DIV_W'(TICK_RATE_HZ);
    assign div_divisor  = freq_nz;

    pwmfd_div #(
        .DW(DIV_W),
        .VW(FREQ_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // sequencer next state
    always_comb begin
        state_next   = state_reg;
        reload_next  = reload_reg;
        compare_next = compare_reg;
        prod_next    = prod_reg;
        case (state_reg)
            S_IDLE:   state_next = S_IDLE;
            S_LOAD_F: state_next = S_FREQ;
            S_FREQ: begin
                if (div_done) begin
                    reload_next = reload_clamp;
                    state_next  = S_MUL;
                end
            end
            S_MUL: begin
                prod_next  = PROD_W'(reload_p1) * PROD_W'(duty_sat);
                state_next = S_SCALE;
            end
            S_SCALE: begin
                compare_next = scaled[RECIP_SH +: CMP_W];
                state_next   = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
        // a new write aborts any run in progress
        if (restart) begin
            state_next = S_LOAD_F;
        end
    end

    // state and pending pair
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            reload_reg  <= CNT_W'(RST_RELOAD);
            compare_reg <= CMP_W'(RST_COMPARE);
        end else begin
            state_reg   <= state_next;
            reload_reg  <= reload_next;
            compare_reg <= compare_next;
        end
    end

    // product operand, no reset needed
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign pend.busy    = (state_reg != S_IDLE);
    assign pend.reload  = reload_reg;
    assign pend.compare = compare_reg;

endmodule

/* design/pwm_generator_freq_duty.sv */
// result: registered, valid in the cycle after its tick item is accepted
// throughput: one item per cycle without a recompute, write or output stall
// after a frequency, duty or enable write the input stalls during recompute:
// the divider load, one divider bit per cycle, then two scaling steps
// reset: synchronous, registers take their defaults, pairs load derived values
// ----------------------------------------------------------------------------
// pwm_generator_freq_duty
// edge-aligned pwm counter with preloaded reload/compare from freq and duty
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "pwm_generator_freq_duty_defines.svh"

module pwm_generator_freq_duty
    import pwmfd_pkg::*;
#(
    parameter int unsigned TICK_RATE_HZ = 1000000,
    parameter int unsigned RELOAD_MAX   = 65535
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_tick,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_pin_level,
    output logic                  m_period_end,
    output logic [CNT_W-1:0]      m_count_value
);

    localparam int RATE_W = $clog2(TICK_RATE_HZ + 1);
    localparam int DIV_W  = (RATE_W > PROD_W) ? RATE_W : PROD_W;

    // reset pair derived from the default frequency and duty
    localparam int unsigned RST_QUOT  = TICK_RATE_HZ / RST_FREQ_HZ;
    localparam int unsigned RST_TICKS = (RST_QUOT > RELOAD_MAX + 1) ? (RELOAD_MAX + 1) :
                                        ((RST_QUOT == 0) ? 1 : RST_QUOT);
    localparam int unsigned RST_RELOAD  = RST_TICKS - 1;
    localparam int unsigned RST_COMPARE = (RST_TICKS * RST_DUTY) / DUTY_MAX;

    logic [FREQ_W-1:0] freq_reg;
    logic [DUTY_W-1:0] duty_reg;
    logic              run_reg;

    logic [CNT_W-1:0]  counter_reg, counter_next;
    logic [CNT_W-1:0]  act_reload_reg, act_reload_next;
    logic [CMP_W-1:0]  act_compare_reg, act_compare_next;
    logic              wrap_next;
    logic              level_next;

    logic              m_valid_reg;
    logic              m_pin_reg;
    logic              m_end_reg;
    logic [CNT_W-1:0]  m_count_reg;

    logic              cfg_hit;
    logic              in_fire;
    pwmfd_pend_t       pend;

    // configuration registers
    assign cfg_hit = cfg_wr_en && ((cfg_wr_index == REG_FREQ) || (cfg_wr_index == REG_DUTY) ||
                                   (cfg_wr_index == REG_RUN));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg <= FREQ_W'(RST_FREQ_HZ);
            duty_reg <= DUTY_W'(RST_DUTY);
            run_reg  <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_FREQ: freq_reg <= cfg_wr_data[FREQ_W-1:0];
                REG_DUTY: duty_reg <= cfg_wr_data[DUTY_W-1:0];
                REG_RUN:  run_reg  <= cfg_wr_data[0];
                default:  ;
            endcase
        end
    end

    // pending pair recompute
    pwmfd_calc #(
        .TICK_RATE_HZ (TICK_RATE_HZ),
        .RELOAD_MAX   (RELOAD_MAX),
        .DIV_W        (DIV_W),
        .RST_RELOAD   (RST_RELOAD),
        .RST_COMPARE  (RST_COMPARE)
    ) u_calc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (cfg_hit),
        .freq    (freq_reg),
        .duty    (duty_reg),
        .pend    (pend)
    );

    // handshake, output register frees as it is taken
    assign s_ready = !pend.busy && !cfg_wr_en && (!m_valid_reg || m_ready);
    assign in_fire = s_valid && s_ready;

    // counter step and preload on wrap
    always_comb begin
        counter_next     = counter_reg;
        act_reload_next  = act_reload_reg;
        act_compare_next = act_compare_reg;
        wrap_next        = 1'b0;
        if (run_reg && s_tick) begin
            if (counter_reg >= act_reload_reg) begin
                counter_next     = '0;
                act_reload_next  = pend.reload;
                act_compare_next = pend.compare;
                wrap_next        = 1'b1;
            end else begin
                counter_next = counter_reg + CNT_W'(1);
            end
        end
        level_next = run_reg && (CMP_W'(counter_next) < act_compare_next);
    end

    // counter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg     <= '0;
            act_reload_reg  <= CNT_W'(RST_RELOAD);
            act_compare_reg <= CMP_W'(RST_COMPARE);
        end else if (in_fire) begin
            counter_reg     <= counter_next;
            act_reload_reg  <= act_reload_next;
            act_compare_reg <= act_compare_next;
        end
    end

    // result item valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result item payload
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_pin_reg   <= level_next;
            m_end_reg   <= wrap_next;
            m_count_reg <= counter_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pin_level   = m_pin_reg;
    assign m_period_end  = m_end_reg;
    assign m_count_value = m_count_reg;

    // checks
    `PWMFD_ASSERT_IMP(a_count_in_period, 1'b1, counter_reg <= act_reload_reg, "counter beyond reload")
    `PWMFD_ASSERT_NXT(a_write_starts_calc, cfg_hit, pend.busy, "write did not start recompute")
    `PWMFD_ASSERT_NXT(a_pin_low_disabled, in_fire && !run_reg, !m_pin_level, "pin high while disabled")

endmodule
